// ===== sv/slrg_pkg.sv =====
// ----------------------------------------------------------------------------
// slrg_pkg
// Shared constants and types of the shuffled Lehmer random generator.
// ----------------------------------------------------------------------------
package slrg_pkg;

  localparam int unsigned XW = 31;              // generator word width
  localparam int unsigned FW = 32;              // Q0.32 fraction width
  localparam int unsigned AW_MUL = 15;          // multiplier constant width
  localparam int unsigned PW = XW + AW_MUL;     // product width

  localparam logic [AW_MUL-1:0] LEHMER_A = 15'd16807;
  localparam logic [XW-1:0]     LEHMER_M = 31'h7FFF_FFFF;
  localparam logic [XW-1:0]     HALF_M   = 31'h3FFF_FFFF;
  localparam logic [FW-1:0]     RNMX_Q32 = 32'd4294966781;
  localparam int unsigned       WARMUP_STEPS = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IMUL,
    ST_IRED,
    ST_MUL,
    ST_RED,
    ST_FRAC,
    ST_EMIT
  } slrg_state_t;

endpackage

// ===== sv/shuffled_lehmer_random_generator.sv =====
// ----------------------------------------------------------------------------
// shuffled_lehmer_random_generator
// Minimal standard Lehmer generator with a Bays-Durham shuffle table.
//
//   channel | dir | tdata bits (low first)                  | tuser
//   in_     | in  | [0] restart, [7:1] zero                 | -
//   out_    | out | [30:0] raw_value, [62:31] unit_fraction | -
//   cfg_    | in  | cfg_wdata = seed_value (31 bits)        | -
//
// A word goes through acceptance, the Lehmer multiply with the table read,
// the fold with the table refill, the fraction setup and the emit, where
// the result is registered. The slot index comes from two constant tables
// and one compare on the previous output. Initialization (first word or
// restart) adds TABLE_DEPTH + 8 Lehmer steps, each through the IMUL and
// IRED states. Reset is synchronous; the shuffle table is not cleared.
// in_tready is low while a word is in progress, and a finished result
// waits in the output register while the next word is accepted; a word
// that reaches the emit step while that register is full stalls there.
// ----------------------------------------------------------------------------
module shuffled_lehmer_random_generator
  import slrg_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  // Input words.
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // [0] restart, [7:1] unused
  // Result words.
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [63:0]   out_tdata,  // [30:0] raw_value, [62:31] unit_fraction
  // Seed register.
  input  logic          cfg_we,
  input  logic [XW-1:0] cfg_wdata
);

  localparam int unsigned QW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned NSTEPS = TABLE_DEPTH + WARMUP_STEPS;
  localparam int unsigned CW = $clog2(NSTEPS);
  localparam logic [31:0] SLOT_DIV = 32'(1 + (32'd2147483646 / TABLE_DEPTH));

  slrg_state_t state_r, state_nxt;

  logic [XW-1:0] seed_r;
  logic [XW-1:0] x_r;
  logic [XW-1:0] last_r;
  logic [CW-1:0] cnt_r;
  logic [XW+1:0] c_r;
  logic          out_valid_r;
  logic [63:0]   out_data_r;

  logic [XW-1:0] lehmer_y;
  logic [XW-1:0] ram_rdata;
  logic          ram_we;
  logic [QW-1:0] ram_waddr;
  logic [QW-1:0] slot;
  logic [7:0]    slot_band;
  logic [8:0]    slot_q;
  logic [8:0]    slot_base [256];
  logic [32:0]   slot_thr [256];
  logic [XW-1:0] seed_fix;
  logic          accept;
  logic          need_init;
  logic          out_free;
  logic [XW+2:0] frac_q;
  logic [XW:0]   frac_t;
  logic [FW-1:0] frac;

  slrg_lehmer u_lehmer (
    .clk (clk),
    .x_i (x_r),
    .y_o (lehmer_y)
  );

  slrg_ram #(
    .WIDTH (XW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (lehmer_y),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  assign accept    = in_tvalid && in_tready;
  assign need_init = in_tdata[0] || (last_r == '0);
  assign seed_fix  = ((seed_r == '0) || (seed_r == LEHMER_M)) ? XW'(1) : seed_r;
  assign out_free  = !out_valid_r || out_tready;

  // With at most 256 slots a slot spans at least 2^23 values, so each band
  // of 2^23 values selected by the top 8 bits touches at most two slots.
  // The tables give the band's first slot and where the next slot starts.
  for (genvar h = 0; h < 256; h++) begin : g_slot_tab
    localparam logic [63:0] BASE = (64'(h) << 23) / 64'(SLOT_DIV);
    assign slot_base[h] = 9'(BASE);
    assign slot_thr[h]  = 33'((BASE + 64'd1) * 64'(SLOT_DIV));
  end

  assign slot_band = last_r[XW-1:XW-8];
  assign slot_q    = slot_base[slot_band]
                   + 9'({2'b0, last_r} >= slot_thr[slot_band]);

  // The index never exceeds the table; the clamp is only a guard.
  assign slot = (32'(slot_q) >= 32'(TABLE_DEPTH)) ? QW'(TABLE_DEPTH - 1) : QW'(slot_q);

  // Fraction: (v * 2^32 + HALF_M) / M, with M = 2^31 - 1, is
  // 2v + floor((2v + HALF_M) / M), and that quotient needs one fold.
  always_comb begin
    frac_t = (XW+1)'(c_r[XW-1:0]) + (XW+1)'(c_r[XW+1:XW]);
    frac_q = (XW+3)'({last_r, 1'b0}) + (XW+3)'(c_r[XW+1:XW])
           + (XW+3)'(frac_t >= (XW+1)'(LEHMER_M));
    if (frac_q > (XW+3)'(RNMX_Q32)) begin
      frac = RNMX_Q32;
    end else begin
      frac = frac_q[FW-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = need_init ? ST_IMUL : ST_MUL;
        end
      end
      ST_IMUL: state_nxt = ST_IRED;
      ST_IRED: state_nxt = (cnt_r == '0) ? ST_MUL : ST_IMUL;
      ST_MUL:  state_nxt = ST_RED;
      ST_RED:  state_nxt = ST_FRAC;
      ST_FRAC: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = slot;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_IRED: begin
        // The last TABLE_DEPTH steps fill the table from the top slot down.
        ram_we    = 32'(cnt_r) < 32'(TABLE_DEPTH);
        ram_waddr = cnt_r[QW-1:0];
      end
      ST_RED:  ram_we = 1'b1;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_r      <= XW'(1);
      x_r         <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept && need_init) begin
            x_r   <= seed_fix;
            cnt_r <= CW'(NSTEPS - 1);
          end
        end
        ST_IRED: begin
          x_r <= lehmer_y;
          if (cnt_r == '0) begin
            last_r <= lehmer_y;
          end else begin
            cnt_r <= cnt_r - CW'(1);
          end
        end
        ST_RED: begin
          x_r    <= lehmer_y;
          last_r <= ram_rdata;
        end
        ST_FRAC: begin
          c_r <= (XW+2)'({last_r, 1'b0}) + (XW+2)'(HALF_M);
        end
        default: begin
          x_r <= x_r;
        end
      endcase
      if (state_r == ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {1'b0, frac, last_r};
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== sv/slrg_ram.sv =====
// ----------------------------------------------------------------------------
// slrg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slrg_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/slrg_lehmer.sv =====
// ----------------------------------------------------------------------------
// slrg_lehmer
// Lehmer step unit: registered 16807 * x, then a Mersenne fold modulo 2^31-1.
// The result is valid in the cycle after the operand is presented.
// ----------------------------------------------------------------------------
module slrg_lehmer
  import slrg_pkg::*;
(
  input  logic          clk,
  input  logic [XW-1:0] x_i,
  output logic [XW-1:0] y_o
);

  logic [PW-1:0] prod_r;
  logic [XW:0]   fold;

  always_ff @(posedge clk) begin
    prod_r <= PW'(x_i) * PW'(LEHMER_A);
  end

  // Since 2^31 is 1 modulo M, the high part simply adds to the low part.
  always_comb begin
    fold = {1'b0, prod_r[XW-1:0]} + (XW+1)'(prod_r[PW-1:XW]);
    if (fold >= {1'b0, LEHMER_M}) begin
      y_o = XW'(fold - {1'b0, LEHMER_M});
    end else begin
      y_o = fold[XW-1:0];
    end
  end

endmodule

// ===== tb/shuffled_lehmer_random_generator_tb.sv =====
// ----------------------------------------------------------------------------
// shuffled_lehmer_random_generator_tb
// Drives request words into the shuffled Lehmer generator and compares every
// result word against a cycle-free software copy of the generator. The copy
// keeps its own seed, Lehmer state and shuffle table. Stimulus is a directed
// pass over seeds and restarts, then long random runs with idling on both
// sides but for one idle-free run, and one long receiver stall.
// ----------------------------------------------------------------------------
module shuffled_lehmer_random_generator_tb
  import slrg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH      = 32;
  localparam int unsigned SLOT_DIV   = 1 + (int'(LEHMER_M) - 1) / DEPTH;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned RAND_RUNS  = 8;
  localparam int unsigned RUN_WORDS  = 225;
  localparam int unsigned PRINT_CAP  = 20;

  typedef struct packed {
    logic [XW-1:0] raw;
    logic [FW-1:0] frac;
  } draw_t;

  logic          clk        = 1'b0;
  logic          rst_n      = 1'b0;
  logic          in_tvalid  = 1'b0;
  logic          in_tready;
  logic [7:0]    in_tdata   = '0;   // [0] restart, [7:1] unused
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [63:0]   out_tdata;         // [30:0] raw_value, [62:31] unit_fraction
  logic          cfg_we     = 1'b0;
  logic [XW-1:0] cfg_wdata  = '0;

  bit in_idle_on   = 1'b1;
  bit out_idle_on  = 1'b1;
  bit hold_request = 1'b0;
  int seeds_written;
  int unsigned cycle_count;

  class lehmer_shuffle_tracker;
    logic [XW-1:0] seed_reg;
    logic [XW-1:0] gen_x;
    logic [XW-1:0] last_draw;
    logic [XW-1:0] slots[DEPTH];
    draw_t         pending_draws[$];
    int            mismatches;
    int            draws_checked;
    int            restarts;

    function new();
      seed_reg  = 1;
      gen_x     = '0;
      last_draw = '0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function automatic logic [XW-1:0] lehmer_step(input logic [XW-1:0] x);
      longint unsigned p;
      p = longint'(LEHMER_A) * longint'(x);
      return XW'(p % longint'(LEHMER_M));
    endfunction

    function void set_seed(input logic [XW-1:0] value);
      seed_reg = value;
    endfunction

    function void note_request(input logic restart);
      logic [XW-1:0]   x;
      int unsigned     slot;
      longint unsigned q;
      draw_t           d;
      // A zero last draw means the table was never filled.
      if (restart || last_draw == '0) begin
        restarts++;
        x = seed_reg;
        if (x == '0 || x == LEHMER_M) x = 1;
        for (int n = DEPTH + WARMUP_STEPS - 1; n >= 0; n--) begin
          x = lehmer_step(x);
          if (n < DEPTH) slots[n] = x;
        end
        gen_x     = x;
        last_draw = slots[0];
      end
      gen_x = lehmer_step(gen_x);
      slot  = last_draw / SLOT_DIV;
      if (slot >= DEPTH) slot = DEPTH - 1;
      d.raw       = slots[slot];
      last_draw   = d.raw;
      slots[slot] = gen_x;
      q = ((longint'(d.raw) << 32) + longint'(HALF_M)) / longint'(LEHMER_M);
      if (q > longint'(RNMX_Q32)) q = longint'(RNMX_Q32);
      d.frac = FW'(q);
      pending_draws.push_back(d);
    endfunction

    function void check_draw(input logic [63:0] word);
      draw_t d;
      if (pending_draws.size() == 0) begin
        mismatches++;
        if (mismatches <= PRINT_CAP)
          $display("%t: unexpected result word, expected none, actual %h", $time, word);
      end else begin
        d = pending_draws.pop_front();
        draws_checked++;
        if (word[30:0] !== d.raw) begin
          mismatches++;
          if (mismatches <= PRINT_CAP)
            $display("%t: raw_value expected %0d actual %0d", $time, d.raw, word[30:0]);
        end
        if (word[62:31] !== d.frac) begin
          mismatches++;
          if (mismatches <= PRINT_CAP)
            $display("%t: unit_fraction expected %0d actual %0d", $time, d.frac,
                     word[62:31]);
        end
      end
    endfunction

    function int pending_count();
      return pending_draws.size();
    endfunction
  endclass

  lehmer_shuffle_tracker tracker = new();

  shuffled_lehmer_random_generator #(.TABLE_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Result side: checks each accepted word, then picks the next tready.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_tvalid && out_tready) tracker.check_draw(out_tdata);
        if (hold_request) begin
          hold_request = 1'b0;
          hold_left    = HOLD_LEN;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_tready <= 1'b0;
        end else begin
          out_tready <= !(out_idle_on && $urandom_range(99) < 21);
        end
      end
    end
  end

  // Leaves in_tvalid high between back-to-back words; lowers it only on a gap.
  task automatic send_word(input logic restart);
    while (in_idle_on && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, restart};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_request(restart);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_seed(input logic [XW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_seed(value);
    seeds_written++;
  endtask

  initial begin
    logic [XW-1:0] seed;
    logic          restart;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first word after reset fills the table even without a restart,
    // using the reset seed.
    send_word(1'b0); send_word(1'b0); send_word(1'b0); send_word(1'b1); send_word(1'b0);
    drain();
    // A seed of zero is replaced by one, and only takes effect on restart.
    write_seed('0);
    send_word(1'b0); send_word(1'b1); send_word(1'b0);
    drain();
    write_seed(LEHMER_M);
    send_word(1'b1); send_word(1'b0);
    drain();
    write_seed(LEHMER_M - 1);
    send_word(1'b1); send_word(1'b0); send_word(1'b0);
    drain();
    write_seed(31'd1);
    send_word(1'b1); send_word(1'b0);
    drain();
    write_seed(31'h5555_5555);
    send_word(1'b1); send_word(1'b0);
    drain();
    write_seed(31'h2AAA_AAAA);
    send_word(1'b1); send_word(1'b0);
    drain();

    for (int run = 0; run < RAND_RUNS; run++) begin
      case ($urandom_range(7))
        0:       seed = '0;
        1:       seed = 31'd1;
        2:       seed = LEHMER_M - 1;
        3:       seed = LEHMER_M;
        default: seed = XW'($urandom);
      endcase
      write_seed(seed);
      in_idle_on  = (run != 2);
      out_idle_on = (run != 2);
      if (run == 4) hold_request = 1'b1;
      for (int i = 0; i < RUN_WORDS; i++) begin
        if (i == 0) restart = 1'($urandom_range(1));
        else restart = ($urandom_range(99) < 3);
        send_word(restart);
      end
      drain();
    end

    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    repeat (20) @(posedge clk);
    $display("tb: %0d result words checked, %0d table fills, %0d seed writes",
             tracker.draws_checked, tracker.restarts, seeds_written);
    $display("tb: included out-of-range seeds, an idle-free run and a %0d-cycle output stall",
             HOLD_LEN);
    if (tracker.mismatches == 0 && tracker.pending_count() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
